[sv/sted_pkg.sv]
// Package: shared types, constants and helpers of the event deduplicator.
`timescale 1ns / 1ps
package sted_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 96;
    localparam int COORD_BITS  = 20;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_W      = CNT_W + 1;

    // Datapath widths
    localparam int TIME_W   = 32;
    localparam int SRC_W    = 32;
    localparam int RAD_W    = 16;
    localparam int R2_W     = 2 * RAD_W;
    localparam int LIMIT_W  = 7;
    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int DSUM_W   = PROD_W + 2;
    localparam int CMP_W    = (DSUM_W > R2_W) ? DSUM_W : R2_W;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DUPLICATE_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS_WINDOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_WINDOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAME_RADIUS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OTHER_RADIUS     = 3'd5;

    // Register reset values
    localparam logic [TIME_W-1:0]  RST_DUPLICATE_WINDOW = 32'd250000;
    localparam logic [TIME_W-1:0]  RST_CROSS_WINDOW     = 32'd50000;
    localparam logic [TIME_W-1:0]  RST_BURST_WINDOW     = 32'd100000;
    localparam logic [LIMIT_W-1:0] RST_BURST_LIMIT      = 7'd16;
    localparam logic [RAD_W-1:0]   RST_SAME_RADIUS      = 16'd256;
    localparam logic [RAD_W-1:0]   RST_OTHER_RADIUS     = 16'd96;

    // Reject causes
    localparam logic [1:0] CAUSE_NONE  = 2'd0;
    localparam logic [1:0] CAUSE_BURST = 2'd1;
    localparam logic [1:0] CAUSE_DUP   = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]            event_time;
        logic [SRC_W-1:0]             source_id;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
    } t_event;

    typedef struct packed {
        logic       accepted;
        logic [1:0] reject_cause;
    } t_result;

    typedef struct packed {
        logic [TIME_W-1:0]  duplicate_window;
        logic [TIME_W-1:0]  cross_window;
        logic [TIME_W-1:0]  burst_window;
        logic [LIMIT_W-1:0] burst_limit;
        logic [RAD_W-1:0]   same_radius;
        logic [RAD_W-1:0]   other_radius;
    } t_cfg;

    // Status of the scan pipeline toward the controller
    typedef struct packed {
        logic             busy;
        logic             dup;
        logic [CNT_W-1:0] burst;
    } t_scan_stat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } t_state;

    // Ring position k entries after base, wrapped once
    function automatic logic [IDX_W-1:0] f_slot(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] k);
        logic [SLOT_W-1:0] s;
        s = SLOT_W'(base) + SLOT_W'(k);
        if (s >= SLOT_W'(TABLE_DEPTH)) begin
            s = s - SLOT_W'(TABLE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    // Magnitude of the difference of two coordinates
    function automatic logic [DIFF_W-1:0] f_abs_diff(input logic signed [COORD_BITS-1:0] a,
                                                     input logic signed [COORD_BITS-1:0] b);
        logic signed [DIFF_W-1:0] d;
        logic [DIFF_W-1:0]        u;
        d = DIFF_W'(a) - DIFF_W'(b);
        u = d;
        return u[DIFF_W-1] ? (~u + 1'b1) : u;
    endfunction

endpackage

[sv/sted_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sted_ram #(
    parameter int DEPTH = 96,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/sted_cmp.sv]
// Scan pipeline: expiry test, burst count and near-duplicate search per entry.
`timescale 1ns / 1ps
module sted_cmp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clr,
    input  logic                 i_valid,
    input  sted_pkg::t_event     i_entry,
    input  sted_pkg::t_event     i_evt,
    input  sted_pkg::t_cfg       i_cfg,
    input  logic [31:0]          i_same_r2,
    input  logic [31:0]          i_other_r2,
    output logic                 o_keep,
    output sted_pkg::t_scan_stat o_stat
);
    import sted_pkg::*;

    logic [TIME_W-1:0] age;
    logic              same;

    logic              r_s2_v, r_s2_burst, r_s2_cmp, r_s2_same;
    logic [DIFF_W-1:0] r_dx, r_dy, r_dz;

    logic              r_s3_v, r_s3_burst, r_s3_cmp, r_s3_same;
    logic [PROD_W-1:0] r_px, r_py, r_pz;

    logic [CMP_W-1:0]  dist_sq;
    logic [CMP_W-1:0]  lim;

    logic              r_dup;
    logic [CNT_W-1:0]  r_burst;

    // Age and expiry of the entry now on the read port
    assign age    = i_evt.event_time - i_entry.event_time;
    assign same   = (i_entry.source_id == i_evt.source_id);
    assign o_keep = i_valid && (age <= i_cfg.duplicate_window);

    // Stage 1: flags and coordinate magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= o_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_burst <= (age <= i_cfg.burst_window);
        r_s2_cmp   <= same || (age <= i_cfg.cross_window);
        r_s2_same  <= same;
        r_dx       <= f_abs_diff(i_entry.pos_x, i_evt.pos_x);
        r_dy       <= f_abs_diff(i_entry.pos_y, i_evt.pos_y);
        r_dz       <= f_abs_diff(i_entry.pos_z, i_evt.pos_z);
    end

    // Stage 2: square each axis
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_burst <= r_s2_burst;
        r_s3_cmp   <= r_s2_cmp;
        r_s3_same  <= r_s2_same;
        r_px       <= r_dx * r_dx;
        r_py       <= r_dy * r_dy;
        r_pz       <= r_dz * r_dz;
    end

    // Stage 3: sum and compare with the squared radius
    assign dist_sq = CMP_W'(r_px) + CMP_W'(r_py) + CMP_W'(r_pz);
    assign lim     = r_s3_same ? CMP_W'(i_same_r2) : CMP_W'(i_other_r2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_dup   <= 1'b0;
            r_burst <= '0;
        end else if (r_s3_v) begin
            if (r_s3_burst) begin
                r_burst <= r_burst + 1'b1;
            end
            if (r_s3_cmp && (dist_sq <= lim)) begin
                r_dup <= 1'b1;
            end
        end
    end

    assign o_stat.busy  = r_s2_v | r_s3_v;
    assign o_stat.dup   = r_dup;
    assign o_stat.burst = r_burst;
endmodule

[sv/spatiotemporal_event_deduplicator_unit.sv]
// Top level: control sequencer, configuration registers and entry memory.
`timescale 1ns / 1ps
// An event is taken when start is high and busy is low; busy then stays high
// until the verdict. The block walks the stored ring once through the single
// read port of the entry memory, one entry per cycle, expiring and packing
// survivors and feeding a three-stage compare pipeline. The walk covers all
// live entries before expiry (at most 96); after the last read the block
// waits for the compare pipeline to drain before it decides on the event.
// The verdict is shown on o_result for exactly one cycle with o_res_valid;
// it cannot be held off, so the receiver must take it in that cycle. busy is
// already low in that cycle. Configuration writes take effect at once and
// are meant to happen while busy is low.
module spatiotemporal_event_deduplicator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  sted_pkg::t_event               i_event,
    input  logic                           i_cfg_we,
    input  logic [sted_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sted_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                           o_res_valid,
    output sted_pkg::t_result              o_result
);
    import sted_pkg::*;

    t_state           r_state, n_state;
    t_cfg             r_cfg;
    t_event           r_evt;
    logic [R2_W-1:0]  r_same_r2, r_other_r2;
    logic [CNT_W-1:0] r_rd_idx, r_kept, r_live_count;
    logic [IDX_W-1:0] r_oldest;
    logic             r_rd_v;
    logic             r_res_valid;
    t_result          r_result;

    logic             accept, issue, decide;
    logic             keep, burst_hit, append, full;
    t_scan_stat       stat;
    t_event           rd_entry;
    logic [$bits(t_event)-1:0] rd_data;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr, pack_addr;
    t_event           ram_wdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duplicate_window <= RST_DUPLICATE_WINDOW;
            r_cfg.cross_window     <= RST_CROSS_WINDOW;
            r_cfg.burst_window     <= RST_BURST_WINDOW;
            r_cfg.burst_limit      <= RST_BURST_LIMIT;
            r_cfg.same_radius      <= RST_SAME_RADIUS;
            r_cfg.other_radius     <= RST_OTHER_RADIUS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DUPLICATE_WINDOW: r_cfg.duplicate_window <= i_cfg_wdata[TIME_W-1:0];
                REG_CROSS_WINDOW:     r_cfg.cross_window     <= i_cfg_wdata[TIME_W-1:0];
                REG_BURST_WINDOW:     r_cfg.burst_window     <= i_cfg_wdata[TIME_W-1:0];
                REG_BURST_LIMIT:      r_cfg.burst_limit      <= i_cfg_wdata[LIMIT_W-1:0];
                REG_SAME_RADIUS:      r_cfg.same_radius      <= i_cfg_wdata[RAD_W-1:0];
                REG_OTHER_RADIUS:     r_cfg.other_radius     <= i_cfg_wdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Square the radii; the user must hold config while an event is in flight, the block does not enforce it
    always_ff @(posedge i_clk) begin
        r_same_r2  <= r_cfg.same_radius * r_cfg.same_radius;
        r_other_r2 <= r_cfg.other_radius * r_cfg.other_radius;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (start) n_state = S_SCAN;
            S_SCAN:   if (r_rd_idx >= r_live_count) n_state = S_DRAIN;
            S_DRAIN:  if (!r_rd_v && !stat.busy) n_state = S_DECIDE;
            S_DECIDE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        busy   = 1'b1;
        issue  = 1'b0;
        decide = 1'b0;
        case (r_state)
            S_IDLE:   busy   = 1'b0;
            S_SCAN:   issue  = (r_rd_idx < r_live_count);
            S_DRAIN:  ;
            S_DECIDE: decide = 1'b1;
            default:  busy   = 1'b0;
        endcase
    end

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch the event transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_evt <= i_event;
        end
    end

    // Walk counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_kept   <= '0;
            r_rd_v   <= 1'b0;
        end else begin
            r_rd_v <= issue;
            if (accept) begin
                r_rd_idx <= '0;
                r_kept   <= '0;
            end else begin
                if (issue) r_rd_idx <= r_rd_idx + 1'b1;
                if (keep)  r_kept   <= r_kept + 1'b1;
            end
        end
    end

    // Verdict
    assign burst_hit = 32'(stat.burst) >= 32'(r_cfg.burst_limit);
    assign append    = decide && !burst_hit && !stat.dup;
    assign full      = (r_kept >= CNT_W'(TABLE_DEPTH));
    assign pack_addr = f_slot(r_oldest, r_kept);

    // Commit ring bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live_count <= '0;
            r_oldest     <= '0;
        end else if (decide) begin
            r_live_count <= (append && !full) ? r_kept + 1'b1 : r_kept;
            if (append && full) begin
                r_oldest <= f_slot(r_oldest, CNT_W'(1));
            end
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= decide;
        end
    end

    always_ff @(posedge i_clk) begin
        if (decide) begin
            r_result.accepted     <= append;
            r_result.reject_cause <= burst_hit ? CAUSE_BURST :
                                     (stat.dup ? CAUSE_DUP : CAUSE_NONE);
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

    // Memory ports: walk reads, pack or append writes
    assign ram_raddr = f_slot(r_oldest, r_rd_idx);
    assign rd_entry  = t_event'(rd_data);
    assign ram_we    = keep || append;
    assign ram_waddr = (append && full) ? r_oldest : pack_addr;
    assign ram_wdata = decide ? r_evt : rd_entry;

    sted_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH ($bits(t_event))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    sted_cmp u_cmp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (accept),
        .i_valid    (r_rd_v),
        .i_entry    (rd_entry),
        .i_evt      (r_evt),
        .i_cfg      (r_cfg),
        .i_same_r2  (r_same_r2),
        .i_other_r2 (r_other_r2),
        .o_keep     (keep),
        .o_stat     (stat)
    );
endmodule

[sv/sted_checker.sv]
// Port-level checker for the event deduplicator, bound to the top level.
`timescale 1ns / 1ps
module sted_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_res_valid,
    input sted_pkg::t_result o_result
);
    import sted_pkg::*;

    // An accepted event keeps the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted event did not raise busy");

    // A verdict only follows a busy period and ends it
    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ($past(busy) && !busy))
        else $error("verdict outside of a busy period");

    // The verdict strobe is never asserted back to back
    a_res_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("verdict strobe longer than one cycle");

    // Accepted flag agrees with the cause, and the cause is a known code
    a_res_coherent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_result.accepted == (o_result.reject_cause == CAUSE_NONE)) &&
                        ((o_result.reject_cause == CAUSE_NONE) ||
                         (o_result.reject_cause == CAUSE_BURST) ||
                         (o_result.reject_cause == CAUSE_DUP)))
        else $error("verdict flag and cause disagree");
endmodule

bind spatiotemporal_event_deduplicator_unit sted_checker u_sted_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_result    (o_result)
);
